/* hw/rtl/mnso_pkg.sv */
// Package for the MIDI note sawtooth oscillator.
// Holds the parser state type, MIDI status constants and the result record.
// No dependencies.
package mnso_pkg;

  localparam int unsigned MultW   = 16;
  localparam int unsigned IncrW   = 32;
  localparam int unsigned PhaseW  = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 8;

  localparam logic [MultW-1:0]  MultReset      = 16'd1000;
  localparam logic [IncrW-1:0]  IncrReset      = 32'd43893;
  localparam logic [ByteW-1:0]  StatusReset    = 8'h90;
  localparam logic [3:0]        NoteOffNibble  = 4'h8;
  localparam logic [3:0]        NoteOnNibble   = 4'h9;

  // cmd field codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdMidi = 1'b1;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhNote = 2'd1,
    PhVel  = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               wrapped;
  } res_t;

endpackage

/* hw/rtl/mnso_in_if.sv */
// Input channel: sample ticks and received MIDI bytes.
// Depends on nothing.
interface mnso_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] midi_byte;

  modport source (output valid, output cmd, output midi_byte, input ready);
  modport sink   (input valid, input cmd, input midi_byte, output ready);
endinterface

/* hw/rtl/mnso_out_if.sv */
// Output channel: sawtooth samples.
// Depends on nothing.
interface mnso_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       wrapped;

  modport source (output valid, output sample, output wrapped, input ready);
  modport sink   (input valid, input sample, input wrapped, output ready);
endinterface

/* hw/rtl/mnso_parser.sv */
// Running-status MIDI parser and phase increment register.
// Depends on mnso_pkg.
module mnso_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mnso_pkg::MultW-1:0]  cfg_wdata_i,
  input  logic                        byte_valid_i,
  input  logic [mnso_pkg::ByteW-1:0]  byte_i,
  output logic [mnso_pkg::IncrW-1:0]  incr_o
);
  import mnso_pkg::*;

  parse_phase_e       state_q, state_d;
  logic [MultW-1:0]   mult_q;
  logic [ByteW-1:0]   status_q, status_d;
  logic [ByteW-1:0]   note_q, note_d;
  logic [IncrW-1:0]   incr_q;
  logic               reload;
  logic signed [MultW+ByteW:0] prod;

  // note is signed, multiplier unsigned
  assign prod = $signed({1'b0, mult_q}) * $signed(note_q);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    note_d   = note_q;
    reload   = 1'b0;
    if (byte_valid_i) begin
      case (state_q)
        PhNote: begin
          note_d  = byte_i;
          state_d = PhVel;
        end
        PhVel: begin
          state_d = PhIdle;
          reload  = 1'b1;
        end
        default: begin
          state_d = PhIdle;
          if (byte_i[7]) begin
            status_d = byte_i;
            if (byte_i[7:4] inside {NoteOffNibble, NoteOnNibble}) begin
              state_d = PhNote;
            end else begin
              reload = 1'b1;
            end
          end else if (status_q[7:4] inside {NoteOffNibble, NoteOnNibble}) begin
            note_d  = byte_i;
            state_d = PhVel;
          end else begin
            reload = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= PhIdle;
      status_q <= StatusReset;
      note_q   <= '0;
      incr_q   <= IncrReset;
      mult_q   <= MultReset;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      note_q   <= note_d;
      if (reload) begin
        incr_q <= {{(IncrW-MultW-ByteW-1){prod[MultW+ByteW]}}, prod};
      end
      if (cfg_we_i) begin
        mult_q <= cfg_wdata_i;
      end
    end
  end

  assign incr_o = incr_q;

endmodule

/* hw/rtl/mnso_accum.sv */
// Phase accumulator with wrap to zero on overflow past 24 bits.
// Depends on mnso_pkg.
module mnso_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tick_i,
  input  logic [mnso_pkg::IncrW-1:0]  incr_i,
  output mnso_pkg::res_t              res_o
);
  import mnso_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [IncrW-1:0]  sum;
  logic              wrap;

  assign sum     = {{(IncrW-PhaseW){1'b0}}, phase_q} + incr_i;
  assign wrap    = |sum[IncrW-1:PhaseW];
  assign phase_d = wrap ? '0 : sum[PhaseW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
    end
  end

  assign res_o.sample  = phase_d[PhaseW-1 -: SampleW];
  assign res_o.wrapped = wrap;

endmodule

/* hw/rtl/mnso_out_stage.sv */
// Output register with skid slot; input stays open until the skid slot fills.
// Depends on mnso_pkg.
module mnso_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  mnso_pkg::res_t res_i,
  output logic           space_o,
  output logic           out_valid_o,
  output mnso_pkg::res_t out_o,
  input  logic           out_ready_i
);
  import mnso_pkg::*;

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic out_fire;

  assign out_fire = out_valid_q & out_ready_i;
  assign space_o  = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* hw/rtl/midi_note_sawtooth_oscillator.sv */
// MIDI note sawtooth oscillator, top level.
// A tick's sample is registered in the output stage; MIDI bytes give no output.
// Throughput: one item per cycle while ready is high; reload = 17x8 mul, tick = 32-bit add.
// A two-slot output stage keeps input ready high unless two samples are waiting.
// Reset (rst_ni, async low): phase 0, increment 43893, status 0x90, multiplier 1000.
// Depends on mnso_pkg, mnso_in_if, mnso_out_if, mnso_parser, mnso_accum, mnso_out_stage.
module midi_note_sawtooth_oscillator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mnso_pkg::MultW-1:0]  cfg_wdata_i,
  mnso_in_if.sink                     in_i,
  mnso_out_if.source                  out_o
);
  import mnso_pkg::*;

  logic             in_xfer;
  logic             space;
  logic [IncrW-1:0] incr;
  res_t             res;
  res_t             out_res;
  logic             out_valid;

  assign in_i.ready = space;
  assign in_xfer    = in_i.valid & space;

  mnso_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (in_xfer && (in_i.cmd == CmdMidi)),
    .byte_i       (in_i.midi_byte),
    .incr_o       (incr)
  );

  mnso_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (in_xfer && (in_i.cmd == CmdTick)),
    .incr_i (incr),
    .res_o  (res)
  );

  mnso_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (in_xfer && (in_i.cmd == CmdTick)),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid),
    .out_o       (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid   = out_valid;
  assign out_o.sample  = out_res.sample;
  assign out_o.wrapped = out_res.wrapped;

endmodule
